// ----- hw/rtl/acs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg: shared types and constants for the auto-levels contrast stretch
// Payload structs, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned QuotW   = 9;   // quotient bits (result may reach 256)

  typedef enum logic [0:0] {
    RegPerChannel     = 1'b0,
    RegColourChannels = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] alpha_in;
    logic       last_pixel;
  } acs_in_t;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] alpha_out;
    logic       last_out;
    logic       adjusted;
  } acs_out_t;

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StDivide  = 4'b0010,
    StResult  = 4'b0100,
    StMeasure = 4'b1000
  } acs_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start divides
    logic step;      // first loads the remainder, then one quotient bit per channel
    logic measure;   // fold captured pixel into statistics
    logic out_load;  // move result into output register
  } acs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_apply;
    logic div_done;
  } acs_sts_t;

endpackage

// ----- hw/rtl/auto_levels_contrast_stretch_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_levels_contrast_stretch_core: min/max auto-levels contrast stretch
// Measure pass gathers min/max, apply pass stretches each used colour byte.
// ----------------------------------------------------------------------------
// One request at a time. A measure request passes through StDivide and
// StMeasure before the next can be accepted; an apply request runs the
// bit-serial divider that forms the 9-bit quotient, hands the result off
// in StResult and waits there while the output register stays stalled.
// The result sits in an output register, so a new request is taken while it
// waits. Configuration is written on cfg_we_i with cfg_idx_i and cfg_wdata_i.
module auto_levels_contrast_stretch_core
  import acs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  acs_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output acs_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i
);

  acs_cmd_t   cmd;
  acs_sts_t   sts;
  logic       full, take;
  logic       per_channel_q;
  logic [1:0] colour_channels_q;

  assign take        = full && !out_stall_i;
  assign out_valid_o = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_channel_q     <= 1'b1;
      colour_channels_q <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPerChannel:     per_channel_q     <= cfg_wdata_i[0];
        RegColourChannels: colour_channels_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  acs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_full_i (full),
    .out_take_i (take),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acs_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_data_i         (in_data_i),
    .per_channel_i     (per_channel_q),
    .colour_channels_i (colour_channels_q),
    .out_take_i        (take),
    .out_full_o        (full),
    .out_data_o        (out_data_o)
  );

  // result handoff never overwrites a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!full || take))
    else $error("output overwritten");

  // accepting a request always issues a capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> cmd.load)
    else $error("accept without capture");

  // a measure request never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.measure |=> !cmd.out_load)
    else $error("measure produced result");

endmodule

// ----- hw/rtl/acs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_ctrl: request sequencer
// Accepts one request at a time, runs the divide loop for apply requests and
// hands results to the output register.
// ----------------------------------------------------------------------------
module acs_ctrl
  import acs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_full_i,
  input  logic     out_take_i,
  input  acs_sts_t sts_i,
  output acs_cmd_t cmd_o
);

  acs_state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDivide;
        end
      end
      StDivide: begin
        if (!sts_i.is_apply) begin
          state_d = StMeasure;
        end else if (sts_i.div_done) begin
          state_d = StResult;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StMeasure: begin
        cmd_o.measure = 1'b1;
        state_d       = StIdle;
      end
      StResult: begin
        if (!out_full_i || out_take_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/acs_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_dpath: statistics and stretch datapath
// Running/held min-max registers and three restoring dividers, one per channel.
// ----------------------------------------------------------------------------
module acs_dpath
  import acs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  acs_cmd_t   cmd_i,
  output acs_sts_t   sts_o,
  input  acs_in_t    in_data_i,
  input  logic       per_channel_i,
  input  logic [1:0] colour_channels_i,
  input  logic       out_take_i,
  output logic       out_full_o,
  output acs_out_t   out_data_o
);

  localparam int unsigned CntW = $clog2(QuotW + 1);

  acs_in_t          req_q;
  logic [7:0]       rmin_q [NumChan];
  logic [7:0]       rmax_q [NumChan];
  logic [7:0]       hmin_q [NumChan];
  logic [7:0]       hmax_q [NumChan];
  logic [17:0]      rem_q  [NumChan];   // partial remainder, up to 510*255+255
  logic [QuotW-1:0] quo_q  [NumChan];
  logic [CntW-1:0]  cnt_q;
  logic             full_q;
  acs_out_t         out_q;

  logic [1:0] nused;
  logic [7:0] v [NumChan];
  logic [7:0] lo, hi;
  logic [NumChan-1:0] str;

  assign nused = (colour_channels_i == 2'd0) ? 2'd1 : colour_channels_i;
  assign v[0]  = req_q.chan0;
  assign v[1]  = req_q.chan1;
  assign v[2]  = req_q.chan2;

  // joint min/max across used channels
  always_comb begin
    lo = v[0];
    hi = v[0];
    for (int c = 1; c < NumChan; c++) begin
      if (c < int'(nused)) begin
        if (v[c] < lo) lo = v[c];
        if (v[c] > hi) hi = v[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      str[c] = (c < int'(nused)) && (hmax_q[c] > hmin_q[c]) &&
               !((hmax_q[c] == 8'd255) && (hmin_q[c] == 8'd0));
    end
  end

  assign sts_o.is_apply = req_q.mode;
  assign sts_o.div_done = (cnt_q == CntW'(QuotW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        rmin_q[c] <= 8'd255;
        rmax_q[c] <= 8'd0;
        hmin_q[c] <= 8'd0;
        hmax_q[c] <= 8'd0;
      end
    end else if (cmd_i.measure) begin
      for (int c = 0; c < NumChan; c++) begin
        logic [7:0] nmin, nmax;
        nmin = rmin_q[c];
        nmax = rmax_q[c];
        if (per_channel_i) begin
          if (c < int'(nused)) begin
            if (v[c] < nmin) nmin = v[c];
            if (v[c] > nmax) nmax = v[c];
          end
        end else begin
          if (lo < nmin) nmin = lo;
          if (hi > nmax) nmax = hi;
        end
        if (req_q.last_pixel) begin
          hmin_q[c] <= nmin;
          hmax_q[c] <= nmax;
          rmin_q[c] <= 8'd255;
          rmax_q[c] <= 8'd0;
        end else begin
          rmin_q[c] <= nmin;
          rmax_q[c] <= nmax;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
  end

  // restoring divide of (510*x + d) by 2d, MSB first over QuotW steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumChan; c++) begin
      logic [7:0]  d8, x8;
      logic [17:0] num, dsh, trial;
      d8  = hmax_q[c] - hmin_q[c];
      x8  = v[c] - hmin_q[c];
      num = 18'(x8) * 18'd510 + 18'(d8);
      if (cmd_i.step && cnt_q == '0) begin
        rem_q[c] <= num;
        quo_q[c] <= '0;
      end
      if (cmd_i.step && cnt_q != '0) begin
        // bit position QuotW-cnt
        dsh   = 18'(d8) << (5'(QuotW) - 5'(cnt_q) + 5'd1);
        trial = rem_q[c] - dsh;
        if (rem_q[c] >= dsh) begin
          rem_q[c] <= trial;
          quo_q[c] <= quo_q[c] | (QuotW'(1) << (QuotW - int'(cnt_q)));
        end
      end
    end
  end

  logic [7:0] res [NumChan];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      logic [17:0] d2, r;
      logic [QuotW-1:0] q;
      d2 = 18'(hmax_q[c] - hmin_q[c]) << 1;
      r  = rem_q[c];
      q  = quo_q[c];
      if (r >= d2) q = q | QuotW'(1); // final bit position zero
      if (!str[c]) res[c] = v[c];
      else if (v[c] <= hmin_q[c]) res[c] = 8'd0;
      else if (q > QuotW'(255)) res[c] = 8'd255;
      else res[c] = q[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      full_q <= 1'b1;
    end else if (out_take_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out0      <= res[0];
      out_q.out1      <= res[1];
      out_q.out2      <= res[2];
      out_q.alpha_out <= req_q.alpha_in;
      out_q.last_out  <= req_q.last_pixel;
      out_q.adjusted  <= |str;
    end
  end

  assign out_full_o = full_q;
  assign out_data_o = out_q;

endmodule

// ----- sim/auto_levels_contrast_stretch_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_levels_contrast_stretch_core_tb: self-checking bench for the core
// Measure and apply passes with random pixels, idle gaps and stalls. Every
// apply result is checked against an in-bench predictor or a directed value.
// ----------------------------------------------------------------------------
module auto_levels_contrast_stretch_core_tb;
  import acs_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  acs_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  acs_out_t   out_data_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;

  auto_levels_contrast_stretch_core DUT (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic       joint_n;
  logic [1:0] chan_cnt;
  logic [7:0] run_lo [3];
  logic [7:0] run_hi [3];
  logic [7:0] frz_lo [3];
  logic [7:0] frz_hi [3];

  acs_out_t pixel_q[$];
  int       errors = 0;
  int       n_results = 0;
  int       n_sent = 0;
  bit       quiet = 1'b0;      // no idling on either side
  bit       hold_off = 1'b0;   // long receiver stall
  bit       done_tx = 1'b0;

  function automatic int unsigned n_used();
    return (chan_cnt == 2'd0) ? 1 : int'(chan_cnt);
  endfunction

  function automatic logic [7:0] stretch_byte(int c, logic [7:0] v);
    int unsigned d, x, q;
    if (v <= frz_lo[c]) return 8'd0;
    d = int'(frz_hi[c]) - int'(frz_lo[c]);
    x = int'(v) - int'(frz_lo[c]);
    q = (510 * x + d) / (2 * d);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic predict_pixel(input acs_in_t px);
    logic [7:0] v [3];
    logic [7:0] lo, hi;
    int         d;
    acs_out_t   r;
    v[0] = px.chan0; v[1] = px.chan1; v[2] = px.chan2;
    if (!px.mode) begin
      if (joint_n) begin
        for (int c = 0; c < n_used(); c++) begin
          if (v[c] < run_lo[c]) run_lo[c] = v[c];
          if (v[c] > run_hi[c]) run_hi[c] = v[c];
        end
      end else begin
        lo = v[0]; hi = v[0];
        for (int c = 1; c < n_used(); c++) begin
          if (v[c] < lo) lo = v[c];
          if (v[c] > hi) hi = v[c];
        end
        for (int c = 0; c < 3; c++) begin
          if (lo < run_lo[c]) run_lo[c] = lo;
          if (hi > run_hi[c]) run_hi[c] = hi;
        end
      end
      if (px.last_pixel) begin
        for (int c = 0; c < 3; c++) begin
          frz_lo[c] = run_lo[c]; frz_hi[c] = run_hi[c];
          run_lo[c] = 8'd255; run_hi[c] = 8'd0;
        end
      end
    end else begin
      r = '0;
      for (int c = 0; c < 3; c++) begin
        d = int'(frz_hi[c]) - int'(frz_lo[c]);
        if (c < n_used() && d > 0 && d != 255) begin
          v[c] = stretch_byte(c, v[c]);
          r.adjusted = 1'b1;
        end
      end
      r.out0 = v[0]; r.out1 = v[1]; r.out2 = v[2];
      r.alpha_out = px.alpha_in;
      r.last_out = px.last_pixel;
      pixel_q.push_back(r);
    end
  endtask

  // valid stays up after an accept until the next falling edge decides
  task automatic send_pixel(input acs_in_t px);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel(px);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [1:0] val);
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);  // a trailing measure request may still be in flight
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegPerChannel) joint_n = val[0];
    else chan_cnt = val;
  endtask

  function automatic acs_in_t mk(logic m, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                 logic [7:0] al, logic l);
    acs_in_t p;
    p.mode = m; p.chan0 = a; p.chan1 = b; p.chan2 = c; p.alpha_in = al; p.last_pixel = l;
    return p;
  endfunction

  function automatic acs_in_t rand_px(logic m, logic l, int lo, int hi);
    return mk(m, 8'($urandom_range(hi, lo)), 8'($urandom_range(hi, lo)),
              8'($urandom_range(hi, lo)), 8'($urandom_range(255)), l);
  endfunction

  // receiver: stall and check
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= !quiet && ($urandom_range(99) < 13);
  end

  always @(posedge clk_i) begin
    acs_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        n_results++;
        if (out_data_o.out0 !== e.out0) begin
          $error("out0 exp %0d got %0d", e.out0, out_data_o.out0); errors++;
        end
        if (out_data_o.out1 !== e.out1) begin
          $error("out1 exp %0d got %0d", e.out1, out_data_o.out1); errors++;
        end
        if (out_data_o.out2 !== e.out2) begin
          $error("out2 exp %0d got %0d", e.out2, out_data_o.out2); errors++;
        end
        if (out_data_o.alpha_out !== e.alpha_out) begin
          $error("alpha_out exp %0d got %0d", e.alpha_out, out_data_o.alpha_out); errors++;
        end
        if (out_data_o.last_out !== e.last_out) begin
          $error("last_out exp %0b got %0b", e.last_out, out_data_o.last_out); errors++;
        end
        if (out_data_o.adjusted !== e.adjusted) begin
          $error("adjusted exp %0b got %0b", e.adjusted, out_data_o.adjusted); errors++;
        end
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (n_sent >= 300);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #50ms;
    $display("auto_levels_contrast_stretch_core test failed");
    $finish;
  end

  // directed table; expected given where obvious, otherwise predictor only
  typedef struct {
    acs_in_t  px;
    bit       has_exp;
    acs_out_t exp;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    acs_in_t  px;
    int       pass_len;
    joint_n = 1'b1; chan_cnt = 2'd3;
    for (int c = 0; c < 3; c++) begin
      run_lo[c] = 8'd255; run_hi[c] = 8'd0; frz_lo[c] = 8'd0; frz_hi[c] = 8'd0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // after reset: everything passes unchanged
    rows.push_back('{mk(1'b1, 8'd0, 8'd128, 8'd255, 8'hA5, 1'b1), 1'b1,
                     '{8'd0, 8'd128, 8'd255, 8'hA5, 1'b1, 1'b0}});
    // full range 0..255 on every channel: pass-through
    rows.push_back('{mk(1'b0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'd77, 8'd200, 8'd3, 8'h5A, 1'b0), 1'b1,
                     '{8'd77, 8'd200, 8'd3, 8'h5A, 1'b0, 1'b0}});
    // range 10..20 / 10..10 / 0..254
    rows.push_back('{mk(1'b0, 8'd10, 8'd10, 8'd0, 8'h00, 1'b0), 1'b0, '0});
    rows.push_back('{mk(1'b0, 8'd20, 8'd10, 8'd254, 8'h00, 1'b1), 1'b0, '0});
    rows.push_back('{mk(1'b1, 8'd20, 8'd99, 8'd254, 8'h11, 1'b0), 1'b1,
                     '{8'd255, 8'd99, 8'd255, 8'h11, 1'b0, 1'b1}});
    rows.push_back('{mk(1'b1, 8'd5, 8'd10, 8'd0, 8'h22, 1'b0), 1'b1,
                     '{8'd0, 8'd10, 8'd0, 8'h22, 1'b0, 1'b1}});
    rows.push_back('{mk(1'b1, 8'd255, 8'd0, 8'd255, 8'hFF, 1'b1), 1'b1,
                     '{8'd255, 8'd0, 8'd255, 8'hFF, 1'b1, 1'b1}});
    rows.push_back('{mk(1'b1, 8'd15, 8'd50, 8'd127, 8'h00, 1'b0), 1'b0, '0});
    foreach (rows[i]) begin
      send_pixel(rows[i].px);
      if (rows[i].has_exp) pixel_q[$] = rows[i].exp;
    end

    // joint mode, two channels, then channel count zero and one
    write_reg(RegPerChannel, 2'd0);
    write_reg(RegColourChannels, 2'd2);
    send_pixel(mk(1'b0, 8'd40, 8'd90, 8'd0, 8'h00, 1'b0));
    send_pixel(mk(1'b0, 8'd60, 8'd70, 8'd255, 8'h00, 1'b1));
    send_pixel(mk(1'b1, 8'd40, 8'd90, 8'd200, 8'h33, 1'b0));
    send_pixel(mk(1'b1, 8'd65, 8'd30, 8'd1, 8'hCC, 1'b1));
    write_reg(RegColourChannels, 2'd0);
    send_pixel(mk(1'b0, 8'd100, 8'd0, 8'd255, 8'h00, 1'b1));
    send_pixel(mk(1'b1, 8'd100, 8'd3, 8'd4, 8'h44, 1'b0));
    write_reg(RegColourChannels, 2'd1);
    write_reg(RegPerChannel, 2'd1);
    send_pixel(mk(1'b0, 8'd30, 8'd1, 8'd2, 8'h00, 1'b0));
    send_pixel(mk(1'b0, 8'd31, 8'd9, 8'd9, 8'h00, 1'b1));
    send_pixel(mk(1'b1, 8'd31, 8'd200, 8'd100, 8'h55, 1'b1));

    // random passes; config changes between some of them
    while (n_sent < 1170) begin
      int lo, hi;
      if ($urandom_range(9) == 0) begin
        write_reg(RegPerChannel, 2'($urandom_range(1)));
        write_reg(RegColourChannels, 2'($urandom_range(3)));
      end
      quiet = ($urandom_range(11) == 0);
      lo = $urandom_range(255);
      hi = $urandom_range(255, lo);
      if ($urandom_range(7) == 0) begin lo = 0; hi = 255; end
      pass_len = $urandom_range(8, 1);
      for (int i = 0; i < pass_len; i++)
        send_pixel(rand_px(1'b0, i == pass_len - 1, lo, hi));
      pass_len = $urandom_range(16, 1);
      for (int i = 0; i < pass_len; i++) begin
        if ($urandom_range(9) == 0) px = rand_px(1'b1, 1'($urandom_range(1)), 0, 255);
        else px = rand_px(1'b1, i == pass_len - 1, lo, hi);
        send_pixel(px);
      end
      if ($urandom_range(9) == 0) send_pixel(rand_px(1'b0, 1'b0, 0, 255));  // stray measure
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("Sent %0d pixels in measure/apply passes, checked %0d stretched results",
             n_sent, n_results);
    $display("Covered joint and per-channel modes, channel counts 0..3, long output stall");
    if (errors == 0) begin
      $display("auto_levels_contrast_stretch_core test passed");
    end else begin
      $display("auto_levels_contrast_stretch_core test failed");
    end
    $finish;
  end

endmodule
